// ===== rtl/rodo_pkg.sv =====
package rodo_pkg;

  localparam int MAX_DIGITS = 16;
  localparam int MAX_RADIX  = 16;
  localparam int DIGIT_W    = 4;
  localparam int COUNT_W    = 5;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int PRODUCT_W  = 2 * CFG_W;

  typedef logic [DIGIT_W-1:0]   digit_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [CFG_W-1:0]     cfg_word_t;
  typedef logic [MAX_RADIX-1:0] value_hot_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_DIGITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 2'd2;

  // action codes
  localparam logic ACT_INCREMENT = 1'b0;
  localparam logic ACT_WRITE_OVF = 1'b1;

  localparam cfg_word_t ACTIVE_MIN  = 5'd1;
  localparam cfg_word_t ACTIVE_MAX  = 5'd16;
  localparam cfg_word_t RADIX_MIN   = 5'd2;
  localparam cfg_word_t RADIX_MAX   = 5'd16;
  localparam cfg_word_t ACTIVE_RST  = 5'd16;
  localparam cfg_word_t RADIX_RST   = 5'd2;
  localparam cfg_word_t TOL_RST     = 5'd1;

  typedef struct packed {
    logic   action;
    logic   overflow_value;
    digit_t count_digit;
  } in_item_t;

  typedef struct packed {
    logic [MAX_DIGITS*DIGIT_W-1:0] counter_digits;
    logic                          overflow_out;
    logic                          all_values_used;
    logic                          counts_non_increasing;
    logic                          counts_balanced;
    count_t                        selected_count;
  } out_item_t;

  typedef struct packed {
    logic      clear;
    logic      step;
    cfg_word_t radix;
  } cell_ctrl_t;

endpackage

// ===== rtl/rodo_cell.sv =====
module rodo_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  rodo_pkg::cell_ctrl_t ctrl,
  input  logic                active,
  input  logic                carry_in,
  output logic                carry_out,
  output rodo_pkg::digit_t    digit,
  output rodo_pkg::value_hot_t value_hot
);
  import rodo_pkg::*;

  digit_t digit_r;
  digit_t digit_nxt;
  logic   wrap;

  assign wrap      = ({1'b0, digit_r} + 5'd1) >= ctrl.radix;
  // inactive positions pass the carry straight to the next cell
  assign carry_out = carry_in & (~active | wrap);
  assign digit     = digit_r;
  assign value_hot = active ? (value_hot_t'(1) << digit_r) : '0;

  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.step && carry_in && active) begin
      digit_nxt = wrap ? '0 : digit_t'(digit_r + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= '0;
    end else begin
      digit_r <= digit_nxt;
    end
  end

endmodule

// ===== rtl/rodo_hist.sv =====
module rodo_hist (
  input  logic                 clk,
  input  logic                 load,
  input  rodo_pkg::value_hot_t value_hot [rodo_pkg::MAX_DIGITS],
  output rodo_pkg::count_t     counts    [rodo_pkg::MAX_RADIX]
);
  import rodo_pkg::*;

  count_t                counts_r   [MAX_RADIX];
  count_t                counts_nxt [MAX_RADIX];
  logic [MAX_DIGITS-1:0] column     [MAX_RADIX];

  // transpose cell one-hots into one column per digit value
  always_comb begin
    for (int v = 0; v < MAX_RADIX; v++) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        column[v][i] = value_hot[i][v];
      end
      counts_nxt[v] = count_t'($countones(column[v]));
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      counts_r <= counts_nxt;
    end
  end

  assign counts = counts_r;

endmodule

// ===== rtl/radix_odometer_with_digit_histogram.sv =====
// out_valid rises once an accepted beat has passed through S_HIST and S_FLAGS
// each item runs the digit update in the cell row, the histogram popcount, then
// the flag stage into the output register; the next item is taken only after that,
// and it is taken while the previous result still waits on out_ready
// reset (synchronous, rst_n low): active_digits 16, radix 2, tolerance 1,
// digits and overflow cleared, no result pending
module radix_odometer_with_digit_histogram (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rodo_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rodo_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [rodo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  rodo_pkg::cfg_word_t            cfg_data
);
  import rodo_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_HIST  = 3'b010,
    S_FLAGS = 3'b100
  } state_t;

  state_t     state_r, state_nxt;
  cfg_word_t  active_r, active_nxt;
  cfg_word_t  radix_r, radix_nxt;
  cfg_word_t  tol_r, tol_nxt;
  logic       ovf_r, ovf_nxt;
  digit_t     sel_r, sel_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  logic       in_fire;
  logic       cfg_clear;
  logic       out_load;
  cell_ctrl_t cell_ctrl;
  logic       carry [MAX_DIGITS+1];
  digit_t     digits [MAX_DIGITS];
  value_hot_t value_hot [MAX_DIGITS];
  count_t     counts [MAX_RADIX];
  logic [MAX_DIGITS*DIGIT_W-1:0] packed_digits;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cfg_clear = cfg_we & ((cfg_index == REG_ACTIVE_DIGITS) ||
                               (cfg_index == REG_RADIX) ||
                               (cfg_index == REG_TOLERANCE));

  assign cell_ctrl.clear = cfg_clear;
  assign cell_ctrl.step  = in_fire & (in_data.action == ACT_INCREMENT);
  assign cell_ctrl.radix = radix_r;

  assign carry[0] = 1'b1;

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    rodo_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (cell_ctrl),
      .active    ({1'b0, 4'(i)} < active_r),
      .carry_in  (carry[i]),
      .carry_out (carry[i+1]),
      .digit     (digits[i]),
      .value_hot (value_hot[i])
    );
    assign packed_digits[i*DIGIT_W +: DIGIT_W] = digits[i];
  end

  rodo_hist u_hist (
    .clk       (clk),
    .load      (state_r == S_HIST),
    .value_hot (value_hot),
    .counts    (counts)
  );

  // configuration; active digits and radix saturate, tolerance is taken as written
  always_comb begin
    active_nxt = active_r;
    radix_nxt  = radix_r;
    tol_nxt    = tol_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_DIGITS: begin
          if (cfg_data < ACTIVE_MIN) active_nxt = ACTIVE_MIN;
          else if (cfg_data > ACTIVE_MAX) active_nxt = ACTIVE_MAX;
          else active_nxt = cfg_data;
        end
        REG_RADIX: begin
          if (cfg_data < RADIX_MIN) radix_nxt = RADIX_MIN;
          else if (cfg_data > RADIX_MAX) radix_nxt = RADIX_MAX;
          else radix_nxt = cfg_data;
        end
        REG_TOLERANCE: begin
          tol_nxt = cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    ovf_nxt = ovf_r;
    sel_nxt = sel_r;
    if (cfg_clear) begin
      ovf_nxt = 1'b0;
    end else if (in_fire) begin
      sel_nxt = in_data.count_digit;
      if (in_data.action == ACT_INCREMENT) begin
        ovf_nxt = ovf_r | carry[MAX_DIGITS];
      end else begin
        ovf_nxt = in_data.overflow_value;
      end
    end
  end

  // summary flags over the registered histogram
  always_comb begin
    logic                        all_used;
    logic                        non_inc;
    logic                        balanced;
    logic signed [PRODUCT_W+1:0] diff;
    logic signed [PRODUCT_W+1:0] bound;
    logic        [PRODUCT_W-1:0] scaled;
    all_used = 1'b1;
    non_inc  = 1'b1;
    balanced = 1'b1;
    bound    = $signed({2'b00, PRODUCT_W'(tol_r) * PRODUCT_W'(radix_r)});
    for (int v = 0; v < MAX_RADIX; v++) begin
      scaled = PRODUCT_W'(radix_r) * PRODUCT_W'(counts[v]);
      diff   = $signed({2'b00, scaled}) - $signed({{(PRODUCT_W+2-CFG_W){1'b0}}, active_r});
      if (diff < 0) diff = -diff;
      if ({1'b0, 4'(v)} < radix_r) begin
        if (counts[v] == '0) all_used = 1'b0;
        if (v > 0 && counts[(v+MAX_RADIX-1)%MAX_RADIX] < counts[v]) non_inc = 1'b0;
        if (!(diff < bound)) balanced = 1'b0;
      end
    end
    out_data_nxt.counter_digits        = packed_digits;
    out_data_nxt.overflow_out          = ovf_r;
    out_data_nxt.all_values_used       = all_used;
    out_data_nxt.counts_non_increasing = non_inc;
    out_data_nxt.counts_balanced       = balanced;
    out_data_nxt.selected_count        = ({1'b0, sel_r} < radix_r) ? counts[sel_r] : '0;
  end

  assign out_load = (state_r == S_FLAGS) & (~out_valid_r | out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_HIST;
      S_HIST:  state_nxt = S_FLAGS;
      S_FLAGS: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= ACTIVE_RST;
      radix_r     <= RADIX_RST;
      tol_r       <= TOL_RST;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      radix_r     <= radix_nxt;
      tol_r       <= tol_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ===== test/odometer_checker.sv =====
module odometer_checker
  import rodo_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  cfg_word_t            cfg_data,
  output int                   pending,
  output int                   fail_count
);

  cfg_word_t digits_in_use;
  cfg_word_t base;
  cfg_word_t spread_limit;

  digit_t odo_digit [MAX_DIGITS];
  count_t histo [MAX_RADIX];
  logic   ovf_sticky;

  out_item_t awaited_readings[$];

  initial fail_count = 0;

  function automatic cfg_word_t saturate(cfg_word_t v, cfg_word_t lo, cfg_word_t hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic clear_odometer();
    int i;
    for (i = 0; i < MAX_DIGITS; i++) odo_digit[i] = '0;
    for (i = 0; i < MAX_RADIX; i++) histo[i] = '0;
    histo[0] = count_t'(digits_in_use);
    ovf_sticky = 1'b0;
  endtask

  task automatic apply_reg_write(logic [CFG_IDX_W-1:0] idx, cfg_word_t val);
    case (idx)
      REG_ACTIVE_DIGITS: begin
        digits_in_use = saturate(val, ACTIVE_MIN, ACTIVE_MAX);
        clear_odometer();
      end
      REG_RADIX: begin
        base = saturate(val, RADIX_MIN, RADIX_MAX);
        clear_odometer();
      end
      REG_TOLERANCE: begin
        spread_limit = val;
        clear_odometer();
      end
      default: ;  // unknown index leaves the store alone
    endcase
  endtask

  function automatic out_item_t advance_odometer(in_item_t item);
    out_item_t r;
    logic      carry;
    int        i, nxt, diff, bound;
    r = '0;
    if (item.action == ACT_INCREMENT) begin
      carry = 1'b1;
      for (i = 0; i < MAX_DIGITS; i++) begin
        if (carry && i < int'(digits_in_use)) begin
          // wide sum so that digit 15 carries in base 16
          nxt = int'(odo_digit[i]) + 1;
          if (histo[odo_digit[i]] != 0) histo[odo_digit[i]]--;
          carry = 1'b0;
          if (nxt >= int'(base)) begin
            nxt = 0;
            carry = 1'b1;
          end
          odo_digit[i] = digit_t'(nxt);
          histo[odo_digit[i]]++;
        end
      end
      if (carry) ovf_sticky = 1'b1;
    end else begin
      ovf_sticky = item.overflow_value;
    end

    for (i = 0; i < MAX_DIGITS; i++) r.counter_digits[DIGIT_W*i +: DIGIT_W] = odo_digit[i];
    r.overflow_out          = ovf_sticky;
    r.all_values_used       = 1'b1;
    r.counts_non_increasing = 1'b1;
    r.counts_balanced       = 1'b1;
    bound = int'(spread_limit) * int'(base);
    for (i = 0; i < int'(base); i++) begin
      diff = int'(base) * int'(histo[i]) - int'(digits_in_use);
      if (diff < 0) diff = -diff;
      if (histo[i] == 0) r.all_values_used = 1'b0;
      if (i > 0 && histo[i-1] < histo[i]) r.counts_non_increasing = 1'b0;
      if (!(diff < bound)) r.counts_balanced = 1'b0;
    end
    r.selected_count = (item.count_digit < base) ? histo[item.count_digit] : '0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s at %0t: got %h, expected %h", what, $time, got, want);
    fail_count++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t fresh;
    if (!rst_n) begin
      digits_in_use = ACTIVE_RST;
      base          = RADIX_RST;
      spread_limit  = TOL_RST;
      clear_odometer();
      awaited_readings.delete();
      pending <= 0;
    end else begin
      if (cfg_we) apply_reg_write(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        fresh = advance_odometer(in_data);
        awaited_readings.insert(awaited_readings.size(), fresh);
      end
      if (out_valid && out_ready) begin
        if (awaited_readings.size() == 0) begin
          report_mismatch("unexpected result beat", out_data.counter_digits, '0);
        end else begin
          want = awaited_readings.pop_front();
          check_field("counter_digits", out_data.counter_digits, want.counter_digits);
          check_field("overflow_out", 64'(out_data.overflow_out), 64'(want.overflow_out));
          check_field("all_values_used", 64'(out_data.all_values_used),
                      64'(want.all_values_used));
          check_field("counts_non_increasing", 64'(out_data.counts_non_increasing),
                      64'(want.counts_non_increasing));
          check_field("counts_balanced", 64'(out_data.counts_balanced),
                      64'(want.counts_balanced));
          check_field("selected_count", 64'(out_data.selected_count),
                      64'(want.selected_count));
        end
      end
      pending <= awaited_readings.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import rodo_pkg::*;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  cfg_word_t            cfg_data;

  int   pending;
  int   fail_count;
  logic tx_idle;
  logic rx_idle;

  radix_odometer_with_digit_histogram i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  odometer_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  task automatic send_item(logic act, logic ovf, digit_t dig);
    int       gap;
    in_item_t item;
    item.action         = act;
    item.overflow_value = ovf;
    item.count_digit    = dig;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // leaves cfg_we high, the caller drops it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, cfg_word_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_config(cfg_word_t act_digits, cfg_word_t rdx, cfg_word_t tol);
    wait_idle();
    write_reg(REG_ACTIVE_DIGITS, act_digits);
    write_reg(REG_RADIX, rdx);
    write_reg(REG_TOLERANCE, tol);
    cfg_we <= 1'b0;
  endtask

  // result side: random stall before each beat while rx_idle is set
  initial begin
    int stall;
    out_ready <= 1'b0;
    forever begin
      stall = rx_idle ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int        ph, k, eff_radix;
    cfg_word_t a, r, t;
    logic      act;
    digit_t    dig;

    tx_idle   = 1'b0;
    rx_idle   = 1'b1;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: 16 digits, base 2, tolerance 1
    send_item(ACT_INCREMENT, 1'b0, 4'd0);
    send_item(ACT_INCREMENT, 1'b1, 4'd1);
    send_item(ACT_INCREMENT, 1'b0, 4'd15);
    send_item(ACT_WRITE_OVF, 1'b1, 4'd0);
    send_item(ACT_WRITE_OVF, 1'b0, 4'd1);

    // too low values saturate, zero tolerance never balances
    tx_idle = 1'b1;
    set_config(5'd0, 5'd1, 5'd0);
    send_item(ACT_INCREMENT, 1'b0, 4'd1);
    send_item(ACT_INCREMENT, 1'b0, 4'd0);
    send_item(ACT_INCREMENT, 1'b1, 4'd1);
    send_item(ACT_WRITE_OVF, 1'b0, 4'd1);
    // write to a missing register must not clear the digits
    wait_idle();
    write_reg(REG_NONE, 5'd31);
    cfg_we <= 1'b0;
    send_item(ACT_INCREMENT, 1'b0, 4'd0);

    // too high digit count and radix saturate to the maxima
    rx_idle = 1'b0;
    set_config(5'd31, 5'd31, 5'd31);
    send_item(ACT_INCREMENT, 1'b0, 4'd15);
    send_item(ACT_INCREMENT, 1'b0, 4'd1);
    send_item(ACT_INCREMENT, 1'b0, 4'd0);
    send_item(ACT_WRITE_OVF, 1'b1, 4'd14);

    set_config(5'd16, 5'd16, 5'd16);
    send_item(ACT_INCREMENT, 1'b0, 4'd2);
    send_item(ACT_INCREMENT, 1'b0, 4'd0);

    // four digits base 2: histogram passes through balanced states
    rx_idle = 1'b1;
    set_config(5'd4, 5'd2, 5'd1);
    for (k = 0; k < 5; k++) send_item(ACT_INCREMENT, 1'b0, digit_t'(k % 2));

    for (ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: begin
          a = cfg_word_t'($urandom_range(1, 3));
          r = cfg_word_t'($urandom_range(2, 16));
        end
        1: begin
          a = cfg_word_t'($urandom_range(1, 6));
          r = cfg_word_t'($urandom_range(2, 3));
        end
        2: begin
          a = cfg_word_t'($urandom_range(0, 31));
          r = cfg_word_t'($urandom_range(0, 31));
        end
        default: begin
          a = 5'd16;
          r = 5'd2;
        end
      endcase
      t = cfg_word_t'($urandom_range(0, 31));
      if (ph == 9) begin
        a = 5'd1;
        r = 5'd16;
        t = 5'd0;
      end
      tx_idle = (ph % 3 != 1);
      rx_idle = (ph % 3 != 2);
      set_config(a, r, t);
      eff_radix = (r < RADIX_MIN) ? int'(RADIX_MIN) : (r > RADIX_MAX) ? int'(RADIX_MAX) : int'(r);
      for (k = 0; k < 110; k++) begin
        act = ($urandom_range(0, 7) == 0) ? ACT_WRITE_OVF : ACT_INCREMENT;
        dig = $urandom_range(0, 1) ? digit_t'($urandom_range(0, 15))
                                   : digit_t'($urandom_range(0, eff_radix - 1));
        send_item(act, 1'($urandom_range(0, 1)), dig);
      end
    end

    wait_idle();
    repeat (5) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
